// ===== design/pcr_pkg.sv =====
// Shared constants and controller/datapath interface types for the RMSD block.
package pcr_pkg;

   localparam int COORD_WIDTH  = 20;
   localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
   localparam int SQ_WIDTH     = 2 * COORD_WIDTH + 1;
   localparam int MAX_ATOMS    = 65536;
   localparam int COUNT_WIDTH  = 17;
   localparam int SUM_WIDTH    = 61;
   localparam int WORK_WIDTH   = SUM_WIDTH + 1;
   localparam int ROOT_WIDTH   = WORK_WIDTH / 2;
   localparam int SREM_WIDTH   = ROOT_WIDTH + 2;
   localparam int DEV_WIDTH    = 21;
   localparam int DIV_STEPS    = WORK_WIDTH;
   localparam int SQRT_STEPS   = ROOT_WIDTH;
   localparam int DRAIN_CYCLES = 3;
   localparam int ITER_WIDTH   = 6;
   localparam int REQ_WIDTH    = 6 * COORD_WIDTH;
   localparam int RSP_WIDTH    = 40;

   typedef struct packed {
      logic accept;
      logic load_div;
      logic div_step;
      logic sqrt_step;
      logic load_out;
   } pcr_cmd_type;

   typedef struct packed {
      logic out_stall;
   } pcr_status_type;

endpackage

// ===== design/pcr_ctrl.sv =====
// Sequencer for accumulation, drain, divide, square root and result delivery.
module pcr_ctrl
   import pcr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic           req_tlast,
   input  pcr_status_type status,
   output logic           req_tready,
   output pcr_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_DRAIN,
      ST_DIVIDE,
      ST_ROOT,
      ST_DELIVER
   } state_type;

   state_type             state_ff, state_in;
   logic [ITER_WIDTH-1:0] iter_ff, iter_in;

   always_comb begin
      state_in      = state_ff;
      iter_in       = iter_ff;
      req_tready    = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_ACCUM: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = ST_DRAIN;
               iter_in  = ITER_WIDTH'(DRAIN_CYCLES);
            end
         end
         ST_DRAIN: begin
            if (iter_ff == '0) begin
               cmd.load_div = 1'b1;
               state_in     = ST_DIVIDE;
               iter_in      = ITER_WIDTH'(DIV_STEPS - 1);
            end else begin
               iter_in = iter_ff - 1'b1;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (iter_ff == '0) begin
               state_in = ST_ROOT;
               iter_in  = ITER_WIDTH'(SQRT_STEPS - 1);
            end else begin
               iter_in = iter_ff - 1'b1;
            end
         end
         ST_ROOT: begin
            cmd.sqrt_step = 1'b1;
            if (iter_ff == '0) begin
               state_in = ST_DELIVER;
            end else begin
               iter_in = iter_ff - 1'b1;
            end
         end
         ST_DELIVER: begin
            if (!status.out_stall) begin
               cmd.load_out = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

endmodule

// ===== design/pcr_datapath.sv =====
// Squared-distance pipeline, accumulator, serial divider, serial square root and output register.
module pcr_datapath
   import pcr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  pcr_cmd_type            cmd,
   input  logic [REQ_WIDTH-1:0]   req_tdata,
   input  logic                   req_tlast,
   output pcr_status_type         status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_WIDTH-1:0]   rsp_tdata,
   output logic                   rsp_tuser
);

   logic signed [COORD_WIDTH-1:0] ref_x, ref_y, ref_z, cmp_x, cmp_y, cmp_z;
   logic signed [DIFF_WIDTH-1:0]  dx, dy, dz;
   logic [DIFF_WIDTH-1:0]         mag_x_ff, mag_y_ff, mag_z_ff;
   logic [DIFF_WIDTH-1:0]         mag_x_in, mag_y_in, mag_z_in;
   logic [2*DIFF_WIDTH-1:0]       prod_x, prod_y, prod_z;
   logic [SQ_WIDTH-1:0]           sq_x_ff, sq_y_ff, sq_z_ff;
   logic                          add_a_ff, add_a_in, add_b_ff;
   logic [SUM_WIDTH:0]            sum_total;
   logic [SUM_WIDTH-1:0]          sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in, count_next;
   logic                          ovf_ff, ovf_in, ovf_next;
   logic [COUNT_WIDTH-1:0]        final_count_ff, final_count_in;
   logic                          final_ovf_ff, final_ovf_in;
   logic [COUNT_WIDTH-1:0]        divisor;
   logic [WORK_WIDTH-1:0]         work_ff, work_in;
   logic [COUNT_WIDTH-1:0]        drem_ff, drem_in;
   logic [COUNT_WIDTH:0]          drem_shift;
   logic [SREM_WIDTH-1:0]         srem_ff, srem_in;
   logic [SREM_WIDTH+1:0]         srem_shift, srem_trial;
   logic [ROOT_WIDTH-1:0]         root_ff, root_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_WIDTH-1:0]          rsp_data_ff, rsp_data_in;
   logic                          rsp_user_ff, rsp_user_in;

   assign ref_x = req_tdata[0*COORD_WIDTH +: COORD_WIDTH];
   assign ref_y = req_tdata[1*COORD_WIDTH +: COORD_WIDTH];
   assign ref_z = req_tdata[2*COORD_WIDTH +: COORD_WIDTH];
   assign cmp_x = req_tdata[3*COORD_WIDTH +: COORD_WIDTH];
   assign cmp_y = req_tdata[4*COORD_WIDTH +: COORD_WIDTH];
   assign cmp_z = req_tdata[5*COORD_WIDTH +: COORD_WIDTH];

   assign dx = DIFF_WIDTH'(ref_x) - DIFF_WIDTH'(cmp_x);
   assign dy = DIFF_WIDTH'(ref_y) - DIFF_WIDTH'(cmp_y);
   assign dz = DIFF_WIDTH'(ref_z) - DIFF_WIDTH'(cmp_z);

   assign prod_x = (2*DIFF_WIDTH)'(mag_x_ff) * (2*DIFF_WIDTH)'(mag_x_ff);
   assign prod_y = (2*DIFF_WIDTH)'(mag_y_ff) * (2*DIFF_WIDTH)'(mag_y_ff);
   assign prod_z = (2*DIFF_WIDTH)'(mag_z_ff) * (2*DIFF_WIDTH)'(mag_z_ff);

   assign sum_total = (SUM_WIDTH+1)'(sum_ff) + (SUM_WIDTH+1)'(sq_x_ff)
                    + (SUM_WIDTH+1)'(sq_y_ff) + (SUM_WIDTH+1)'(sq_z_ff);

   assign divisor    = (final_count_ff == '0) ? COUNT_WIDTH'(1) : final_count_ff;
   assign drem_shift = {drem_ff, work_ff[WORK_WIDTH-1]};
   assign srem_shift = {srem_ff, work_ff[WORK_WIDTH-1 -: 2]};
   assign srem_trial = {2'b00, root_ff, 2'b01};

   assign status.out_stall = rsp_valid_ff && !rsp_tready;

   always_comb begin
      mag_x_in       = dx[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dx) : DIFF_WIDTH'(dx);
      mag_y_in       = dy[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dy) : DIFF_WIDTH'(dy);
      mag_z_in       = dz[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dz) : DIFF_WIDTH'(dz);
      add_a_in       = 1'b0;
      count_next     = count_ff;
      ovf_next       = ovf_ff;
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      final_count_in = final_count_ff;
      final_ovf_in   = final_ovf_ff;
      sum_in         = sum_ff;
      work_in        = work_ff;
      drem_in        = drem_ff;
      srem_in        = srem_ff;
      root_in        = root_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;

      if (cmd.accept) begin
         if (count_ff == COUNT_WIDTH'(MAX_ATOMS)) begin
            ovf_next = 1'b1;
         end else begin
            count_next = count_ff + 1'b1;
            add_a_in   = 1'b1;
         end
         count_in = count_next;
         ovf_in   = ovf_next;
         if (req_tlast) begin
            final_count_in = count_next;
            final_ovf_in   = ovf_next;
            count_in       = '0;
            ovf_in         = 1'b0;
         end
      end

      if (add_b_ff) begin
         sum_in = sum_total[SUM_WIDTH] ? '1 : sum_total[SUM_WIDTH-1:0];
      end

      if (cmd.load_div) begin
         work_in = {1'b0, sum_ff};
         drem_in = '0;
         srem_in = '0;
         root_in = '0;
         sum_in  = '0;
      end

      if (cmd.div_step) begin
         if (drem_shift >= {1'b0, divisor}) begin
            drem_in = COUNT_WIDTH'(drem_shift - {1'b0, divisor});
            work_in = {work_ff[WORK_WIDTH-2:0], 1'b1};
         end else begin
            drem_in = drem_shift[COUNT_WIDTH-1:0];
            work_in = {work_ff[WORK_WIDTH-2:0], 1'b0};
         end
      end

      if (cmd.sqrt_step) begin
         work_in = {work_ff[WORK_WIDTH-3:0], 2'b00};
         if (srem_shift >= srem_trial) begin
            srem_in = SREM_WIDTH'(srem_shift - srem_trial);
            root_in = {root_ff[ROOT_WIDTH-2:0], 1'b1};
         end else begin
            srem_in = srem_shift[SREM_WIDTH-1:0];
            root_in = {root_ff[ROOT_WIDTH-2:0], 1'b0};
         end
      end

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_WIDTH'({final_count_ff, root_ff[DEV_WIDTH-1:0]});
         rsp_user_in  = final_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag_x_ff       <= mag_x_in;
      mag_y_ff       <= mag_y_in;
      mag_z_ff       <= mag_z_in;
      sq_x_ff        <= prod_x[SQ_WIDTH-1:0];
      sq_y_ff        <= prod_y[SQ_WIDTH-1:0];
      sq_z_ff        <= prod_z[SQ_WIDTH-1:0];
      final_count_ff <= final_count_in;
      final_ovf_ff   <= final_ovf_in;
      work_ff        <= work_in;
      drem_ff        <= drem_in;
      srem_ff        <= srem_in;
      root_ff        <= root_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         add_a_ff     <= 1'b0;
         add_b_ff     <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         add_a_ff     <= add_a_in;
         add_b_ff     <= add_a_ff;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== design/paired_coordinate_rmsd.sv =====
// Top level of the paired-coordinate RMSD block: controller and datapath.
//
// The block takes one atom-pair beat per clock while a group is open; each pair's squared
// distance goes through a three-stage pipeline into the running sum. After the beat marked
// tlast, req_tready stays low while the controller drains the pipeline and loads the divider,
// runs the one-bit-per-cycle divider and the one-bit-per-cycle square root, and loads the
// result register, and also for as long as a still-unread previous result holds the output
// register. A result register separates the two sides, so a new group may stream in while a
// result waits.
module paired_coordinate_rmsd
   import pcr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // ref_x, ref_y, ref_z, cmp_x, cmp_y, cmp_z, 20 bits each.
   input  logic [REQ_WIDTH-1:0] req_tdata,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // deviation (21 bits), pair_count (17 bits), two zero bits.
   output logic [RSP_WIDTH-1:0] rsp_tdata,
   // overflow.
   output logic                 rsp_tuser
);

   pcr_cmd_type    cmd;
   pcr_status_type status;

   pcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   pcr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
